// File: hdl/mtkte_pkg.sv
// Shared types, codes and letter tables for the multi-tap keypad text entry block.
// No dependencies; the front, queue, back and top-level files import this package.
`timescale 1ns / 1ps
`default_nettype none

package mtkte_pkg;

   // Input command codes.
   typedef enum logic [2:0] {
      CMD_PRESS     = 3'd0,
      CMD_TICK      = 3'd1,
      CMD_SPACE     = 3'd2,
      CMD_ENTER     = 3'd3,
      CMD_BACKSPACE = 3'd4,
      CMD_SHIFT     = 3'd5
   } cmd_type;

   // Result action codes.
   typedef enum logic [1:0] {
      ACT_APPEND  = 2'd0,
      ACT_DELETE  = 2'd1,
      ACT_PREVIEW = 2'd2
   } action_type;

   // Register map: byte address bits and register indexes.
   localparam int CSR_ADDR_BITS = 3;
   localparam logic CSR_IDX_TIMEOUT = 1'b0;
   localparam logic [15:0] TIMEOUT_RESET = 16'd800;

   // Queue between the front and back parts.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_BITS = 2;

   localparam logic [6:0] ASCII_SPACE = 7'h20;
   localparam logic [6:0] ASCII_NEWLINE = 7'h0A;
   localparam logic [7:0] LOWER_OFFSET = 8'd32;

   // Upper-case letters of each key group; unused slots hold zero.
   localparam logic [7:0] LETTERS [8][4] = '{
      '{8'h41, 8'h42, 8'h43, 8'h00},
      '{8'h44, 8'h45, 8'h46, 8'h00},
      '{8'h47, 8'h48, 8'h49, 8'h00},
      '{8'h4A, 8'h4B, 8'h4C, 8'h00},
      '{8'h4D, 8'h4E, 8'h4F, 8'h00},
      '{8'h50, 8'h51, 8'h52, 8'h53},
      '{8'h54, 8'h55, 8'h56, 8'h00},
      '{8'h57, 8'h58, 8'h59, 8'h5A}
   };

   // One classified input item: up to two results plus the preview after the step.
   typedef struct packed {
      logic       two;
      action_type act0;
      logic [6:0] code0;
      action_type act1;
      logic [6:0] code1;
      logic       pv;
      logic [6:0] pc;
   } rec_type;

   // Number of letters on a key group.
   function automatic logic [2:0] group_size(input logic [2:0] grp);
      logic [2:0] size;
      size = ((grp == 3'd5) || (grp == 3'd7)) ? 3'd4 : 3'd3;
      return size;
   endfunction

   // ASCII of a letter in the given case.
   function automatic logic [6:0] letter_ascii(input logic [2:0] grp, input logic [1:0] idx,
                                               input logic upper);
      logic [7:0] c;
      c = LETTERS[grp][idx];
      if (!upper) begin
         c = c + LOWER_OFFSET;
      end
      return c[6:0];
   endfunction

endpackage

`default_nettype wire

// File: hdl/mtkte_if.sv
// Valid/ready channel interfaces for the keypad input words and result words.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface mtkte_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] cmd;
   logic [2:0] key_group;
   logic       shift_level;

   modport source (output valid, cmd, key_group, shift_level, input ready);
   modport sink (input valid, cmd, key_group, shift_level, output ready);
endinterface

interface mtkte_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [6:0] char_code;
   logic       preview_valid;
   logic [6:0] preview_char;
   logic       last;

   modport source (output valid, action, char_code, preview_valid, preview_char, last,
                   input ready);
   modport sink (input valid, action, char_code, preview_valid, preview_char, last,
                 output ready);
endinterface

`default_nettype wire

// File: hdl/mtkte_front.sv
// Front part: accepts keypad words, keeps the pending-letter state and classifies
// each word into a record of results. Depends on mtkte_pkg and mtkte_if.
`timescale 1ns / 1ps
`default_nettype none

module mtkte_front #(
   parameter int TIMER_BITS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   mtkte_req_if.sink              req,
   input  wire logic [15:0]       timeout,
   input  wire logic              queue_full,
   output      logic              push_valid,
   output      mtkte_pkg::rec_type push_data
);
   import mtkte_pkg::*;

   logic                  pend_valid_ff, pend_valid_in;
   logic [2:0]            group_ff, group_in;
   logic [1:0]            index_ff, index_in;
   logic                  upper_ff, upper_in;
   logic [TIMER_BITS-1:0] count_ff, count_in;
   logic                  accept;
   logic                  emit;
   logic [6:0]            cur_char;
   logic [6:0]            sep_char;
   logic [2:0]            idx_p1;
   rec_type               rec;

   assign req.ready = !queue_full;
   assign accept = req.valid && req.ready;
   assign cur_char = letter_ascii(group_ff, index_ff, upper_ff);
   assign idx_p1 = {1'b0, index_ff} + 3'd1;
   assign sep_char = (cmd_type'(req.cmd) == CMD_SPACE) ? ASCII_SPACE : ASCII_NEWLINE;

   // Next state and the results of the word on the input.
   always_comb begin
      pend_valid_in = pend_valid_ff;
      group_in = group_ff;
      index_in = index_ff;
      upper_in = upper_ff;
      count_in = count_ff;
      emit = 1'b0;
      rec = '0;
      rec.act0 = ACT_PREVIEW;
      rec.act1 = ACT_PREVIEW;
      unique case (cmd_type'(req.cmd))
         CMD_PRESS: begin
            emit = 1'b1;
            if (pend_valid_ff && (group_ff == req.key_group)) begin
               index_in = (idx_p1 == group_size(req.key_group)) ? 2'd0 : idx_p1[1:0];
            end else begin
               if (pend_valid_ff) begin
                  rec.two = 1'b1;
                  rec.act0 = ACT_APPEND;
                  rec.code0 = cur_char;
               end
               pend_valid_in = 1'b1;
               group_in = req.key_group;
               index_in = 2'd0;
            end
            count_in = TIMER_BITS'(timeout);
         end
         CMD_TICK: begin
            if (pend_valid_ff) begin
               if (count_ff <= TIMER_BITS'(1)) begin
                  emit = 1'b1;
                  rec.act0 = ACT_APPEND;
                  rec.code0 = cur_char;
                  pend_valid_in = 1'b0;
                  group_in = '0;
                  index_in = '0;
                  count_in = '0;
               end else begin
                  count_in = count_ff - TIMER_BITS'(1);
               end
            end
         end
         CMD_SPACE, CMD_ENTER: begin
            emit = 1'b1;
            if (pend_valid_ff) begin
               rec.two = 1'b1;
               rec.act0 = ACT_APPEND;
               rec.code0 = cur_char;
               rec.act1 = ACT_APPEND;
               rec.code1 = sep_char;
            end else begin
               rec.act0 = ACT_APPEND;
               rec.code0 = sep_char;
            end
            pend_valid_in = 1'b0;
            group_in = '0;
            index_in = '0;
            count_in = '0;
         end
         CMD_BACKSPACE: begin
            emit = 1'b1;
            if (pend_valid_ff) begin
               pend_valid_in = 1'b0;
               group_in = '0;
               index_in = '0;
               count_in = '0;
            end else begin
               rec.act0 = ACT_DELETE;
            end
         end
         CMD_SHIFT: begin
            emit = 1'b1;
            upper_in = req.shift_level;
         end
         default: begin
            emit = 1'b0;
         end
      endcase
      // The preview shows the state after the whole step.
      rec.pv = pend_valid_in;
      rec.pc = pend_valid_in ? letter_ascii(group_in, index_in, upper_in) : 7'd0;
   end

   assign push_valid = accept && emit;
   assign push_data = rec;

   // Pending-letter state advances on every accepted word.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         group_ff <= '0;
         index_ff <= '0;
         upper_ff <= 1'b0;
         count_ff <= '0;
      end else if (accept) begin
         pend_valid_ff <= pend_valid_in;
         group_ff <= group_in;
         index_ff <= index_in;
         upper_ff <= upper_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/mtkte_queue.sv
// Short record queue that decouples the front and back parts.
// Depends on mtkte_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mtkte_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push_valid,
   input  wire mtkte_pkg::rec_type push_data,
   output      logic               full,
   output      logic               head_valid,
   output      mtkte_pkg::rec_type head_data,
   input  wire logic               pop
);
   import mtkte_pkg::*;

   rec_type                   entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_BITS:0]   count_ff, count_in;
   logic                      do_pop;

   assign full = (count_ff == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data = entries_ff[rd_ptr_ff];
   assign do_pop = pop && head_valid;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (push_valid && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push_valid && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // Record storage.
   always_ff @(posedge clock) begin
      if (push_valid) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// File: hdl/mtkte_back.sv
// Back part: expands each queued record into one or two result words held in
// an output register. Depends on mtkte_pkg and mtkte_if.
`timescale 1ns / 1ps
`default_nettype none

module mtkte_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               head_valid,
   input  wire mtkte_pkg::rec_type head_data,
   output      logic               pop,
   mtkte_rsp_if.source             rsp
);
   import mtkte_pkg::*;

   logic       phase_ff, phase_in;
   logic       valid_ff, valid_in;
   action_type action_ff, action_in;
   logic [6:0] code_ff, code_in;
   logic       pv_ff;
   logic [6:0] pc_ff;
   logic       last_ff, last_in;
   logic       out_free;
   logic       load;

   assign out_free = !valid_ff || rsp.ready;
   assign load = out_free && head_valid;

   // Pick the next result word of the head record.
   always_comb begin
      phase_in = phase_ff;
      pop = 1'b0;
      valid_in = out_free ? head_valid : valid_ff;
      if (phase_ff) begin
         action_in = head_data.act1;
         code_in = head_data.code1;
         last_in = 1'b1;
      end else begin
         action_in = head_data.act0;
         code_in = head_data.code0;
         last_in = !head_data.two;
      end
      if (load) begin
         if (!phase_ff && head_data.two) begin
            phase_in = 1'b1;
         end else begin
            phase_in = 1'b0;
            pop = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         valid_ff <= valid_in;
      end
   end

   // Output word register.
   always_ff @(posedge clock) begin
      if (load) begin
         action_ff <= action_in;
         code_ff <= code_in;
         pv_ff <= head_data.pv;
         pc_ff <= head_data.pc;
         last_ff <= last_in;
      end
   end

   assign rsp.valid = valid_ff;
   assign rsp.action = action_ff;
   assign rsp.char_code = code_ff;
   assign rsp.preview_valid = pv_ff;
   assign rsp.preview_char = pc_ff;
   assign rsp.last = last_ff;

endmodule

`default_nettype wire

// File: hdl/multi_tap_keypad_text_entry.sv
// Top level of the multi-tap keypad text entry block: register port, front part,
// record queue and back part. Depends on mtkte_pkg, mtkte_if and the mtkte_* modules.
`timescale 1ns / 1ps
`default_nettype none

// The block accepts one keypad word per clock cycle on req_chan while its queue
// is not full, and gives its result words on rsp_chan one per cycle while the
// receiver is ready. The first word of an item passes through the record queue
// and then the output register before it is presented. A key press that commits
// a different pending letter, and a space or enter that commits one, give two
// words; ticks that do not commit give none. A four-record queue between the
// classifier and the output register absorbs such bursts and output stalls;
// input ready falls only while that queue is full. The timeout register at byte
// address 0 may be written at any time the block is idle and takes effect on the
// next press.
module multi_tap_keypad_text_entry #(
   parameter int TIMER_BITS = 16
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   mtkte_req_if.sink                                    req_chan,
   mtkte_rsp_if.source                                  rsp_chan,
   input  wire logic                                    psel,
   input  wire logic                                    penable,
   input  wire logic                                    pwrite,
   input  wire logic [mtkte_pkg::CSR_ADDR_BITS-1:0]     paddr,
   input  wire logic [31:0]                             pwdata,
   output      logic [31:0]                             prdata,
   output      logic                                    pready
);
   import mtkte_pkg::*;

   logic [15:0] timeout_ff;
   logic        cfg_wr;
   logic        cfg_sel_timeout;
   logic        push_valid;
   rec_type     push_data;
   logic        q_full;
   logic        head_valid;
   rec_type     head_data;
   logic        q_pop;

   // Register port: always ready, one register.
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite && pready;
   assign cfg_sel_timeout = (paddr[CSR_ADDR_BITS-1:2] == CSR_IDX_TIMEOUT);
   assign prdata = cfg_sel_timeout ? {16'd0, timeout_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else if (cfg_wr && cfg_sel_timeout) begin
         timeout_ff <= pwdata[15:0];
      end
   end

   mtkte_front #(
      .TIMER_BITS(TIMER_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .timeout    (timeout_ff),
      .queue_full (q_full),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   mtkte_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (q_full),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (q_pop)
   );

   mtkte_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (q_pop),
      .rsp        (rsp_chan)
   );

   // A record leaves the queue only as its final word is loaded.
   a_pop_on_last: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (rsp_chan.valid && rsp_chan.last))
      else $error("record popped without its final word");

   // The second word of a two-word record always follows the first.
   a_second_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.last) |=> rsp_chan.valid)
      else $error("first word of a pair not followed by its second");

   // A timeout write lands in the register.
   a_cfg_write: assert property (@(posedge clock) disable iff (reset)
      (cfg_wr && cfg_sel_timeout) |=> (timeout_ff == $past(pwdata[15:0])))
      else $error("timeout register write lost");

endmodule

`default_nettype wire
